// ----- rtl/qtls_pkg.sv -----
package qtls_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int PT_W     = 10;
	localparam int COEF_W   = 32;
	localparam int OPD_W    = 64;
	localparam int ACC_W    = 128;
	localparam int NCOEF    = 6;
	localparam int PROG_LEN = 33;
	localparam int PC_W     = 6;
	localparam int CI_W     = 3;

	typedef struct packed {
		logic [OPD_W-1:0] a;
		logic [OPD_W-1:0] b;
		logic [OPD_W-1:0] c;
		logic [OPD_W-1:0] d;
		logic [OPD_W-1:0] n;
		logic [OPD_W-1:0] x2;
		logic [OPD_W-1:0] x1;
		logic [OPD_W-1:0] x0;
		logic [OPD_W-1:0] y2;
		logic [OPD_W-1:0] y1;
		logic [OPD_W-1:0] y0;
	} sums_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] x_quad;
		logic signed [COEF_W-1:0] x_lin;
		logic signed [COEF_W-1:0] x_const;
		logic signed [COEF_W-1:0] y_quad;
		logic signed [COEF_W-1:0] y_lin;
		logic signed [COEF_W-1:0] y_const;
		logic                     fit_valid;
	} res_t;

	typedef enum logic [4:0] {
		OP_A, OP_B, OP_C, OP_D, OP_N,
		OP_C0, OP_C1, OP_C2, OP_C3, OP_C4, OP_C5,
		OP_X2, OP_X1, OP_X0, OP_Y2, OP_Y1, OP_Y0
	} opnd_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_COF0, DST_COF1, DST_COF2, DST_COF3, DST_COF4, DST_COF5,
		DST_DET, DST_NUM
	} dst_t;

	typedef struct packed {
		opnd_t xs;
		opnd_t ys;
		logic  neg;
		logic  first;
		dst_t  dst;
	} prog_t;

	localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LEN - 1);

	// cofactors, determinant, then three numerators per axis
	function automatic prog_t prog_at(input logic [PC_W-1:0] pc);
		prog_t p;
		case (pc)
			6'd0:  p = '{OP_C,  OP_N,  1'b0, 1'b1, DST_NONE};
			6'd1:  p = '{OP_D,  OP_D,  1'b1, 1'b0, DST_COF0};
			6'd2:  p = '{OP_C,  OP_D,  1'b0, 1'b1, DST_NONE};
			6'd3:  p = '{OP_B,  OP_N,  1'b1, 1'b0, DST_COF1};
			6'd4:  p = '{OP_B,  OP_D,  1'b0, 1'b1, DST_NONE};
			6'd5:  p = '{OP_C,  OP_C,  1'b1, 1'b0, DST_COF2};
			6'd6:  p = '{OP_A,  OP_N,  1'b0, 1'b1, DST_NONE};
			6'd7:  p = '{OP_C,  OP_C,  1'b1, 1'b0, DST_COF3};
			6'd8:  p = '{OP_B,  OP_C,  1'b0, 1'b1, DST_NONE};
			6'd9:  p = '{OP_A,  OP_D,  1'b1, 1'b0, DST_COF4};
			6'd10: p = '{OP_A,  OP_C,  1'b0, 1'b1, DST_NONE};
			6'd11: p = '{OP_B,  OP_B,  1'b1, 1'b0, DST_COF5};
			6'd12: p = '{OP_A,  OP_C0, 1'b0, 1'b1, DST_NONE};
			6'd13: p = '{OP_B,  OP_C1, 1'b0, 1'b0, DST_NONE};
			6'd14: p = '{OP_C,  OP_C2, 1'b0, 1'b0, DST_DET};
			6'd15: p = '{OP_C0, OP_X2, 1'b0, 1'b1, DST_NONE};
			6'd16: p = '{OP_C1, OP_X1, 1'b0, 1'b0, DST_NONE};
			6'd17: p = '{OP_C2, OP_X0, 1'b0, 1'b0, DST_NUM};
			6'd18: p = '{OP_C1, OP_X2, 1'b0, 1'b1, DST_NONE};
			6'd19: p = '{OP_C3, OP_X1, 1'b0, 1'b0, DST_NONE};
			6'd20: p = '{OP_C4, OP_X0, 1'b0, 1'b0, DST_NUM};
			6'd21: p = '{OP_C2, OP_X2, 1'b0, 1'b1, DST_NONE};
			6'd22: p = '{OP_C4, OP_X1, 1'b0, 1'b0, DST_NONE};
			6'd23: p = '{OP_C5, OP_X0, 1'b0, 1'b0, DST_NUM};
			6'd24: p = '{OP_C0, OP_Y2, 1'b0, 1'b1, DST_NONE};
			6'd25: p = '{OP_C1, OP_Y1, 1'b0, 1'b0, DST_NONE};
			6'd26: p = '{OP_C2, OP_Y0, 1'b0, 1'b0, DST_NUM};
			6'd27: p = '{OP_C1, OP_Y2, 1'b0, 1'b1, DST_NONE};
			6'd28: p = '{OP_C3, OP_Y1, 1'b0, 1'b0, DST_NONE};
			6'd29: p = '{OP_C4, OP_Y0, 1'b0, 1'b0, DST_NUM};
			6'd30: p = '{OP_C2, OP_Y2, 1'b0, 1'b1, DST_NONE};
			6'd31: p = '{OP_C4, OP_Y1, 1'b0, 1'b0, DST_NONE};
			6'd32: p = '{OP_C5, OP_Y0, 1'b0, 1'b0, DST_NUM};
			default: p = '{OP_A, OP_A, 1'b0, 1'b1, DST_NONE};
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/qtls_pt_if.sv -----
interface qtls_pt_if;
	logic                        valid;
	logic                        ready;
	logic [qtls_pkg::PT_W-1:0]   point_x;
	logic [qtls_pkg::PT_W-1:0]   point_y;
	logic                        last_point;

	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// ----- rtl/qtls_fit_if.sv -----
interface qtls_fit_if;
	logic                               valid;
	logic                               ready;
	logic signed [qtls_pkg::COEF_W-1:0] x_quad;
	logic signed [qtls_pkg::COEF_W-1:0] x_lin;
	logic signed [qtls_pkg::COEF_W-1:0] x_const;
	logic signed [qtls_pkg::COEF_W-1:0] y_quad;
	logic signed [qtls_pkg::COEF_W-1:0] y_lin;
	logic signed [qtls_pkg::COEF_W-1:0] y_const;
	logic                               fit_valid;
	logic                               points_dropped;

	modport source (output valid, x_quad, x_lin, x_const, y_quad, y_lin, y_const,
		fit_valid, points_dropped, input ready);
	modport sink (input valid, x_quad, x_lin, x_const, y_quad, y_lin, y_const,
		fit_valid, points_dropped, output ready);
endinterface

// ----- rtl/qtls_accum.sv -----
module qtls_accum #(
	parameter int MAX_POINTS = qtls_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = qtls_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [qtls_pkg::PT_W-1:0] px,
	input  logic [qtls_pkg::PT_W-1:0] py,
	input  logic                      clr,
	output qtls_pkg::sums_t           sums,
	output logic                      ov
);
	localparam int CB   = (COORD_BITS < qtls_pkg::PT_W) ? COORD_BITS : qtls_pkg::PT_W;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int P2W  = 2 * CW;
	localparam int P3W  = 3 * CW;
	localparam int P4W  = 4 * CW;
	localparam int S1W  = 2 * CW;
	localparam int S2W  = 3 * CW;
	localparam int S3W  = 4 * CW;
	localparam int S4W  = 5 * CW;
	localparam int SXW  = CW + CB;
	localparam int SIXW = 2 * CW + CB;
	localparam int S2XW = 3 * CW + CB;
	localparam int OW   = qtls_pkg::OPD_W;

	logic [CW-1:0]   cnt_q;
	logic [P2W-1:0]  p2_q;
	logic [P3W-1:0]  p3_q;
	logic [P4W-1:0]  p4_q;
	logic [S1W-1:0]  s1_q;
	logic [S2W-1:0]  s2_q;
	logic [S3W-1:0]  s3_q;
	logic [S4W-1:0]  s4_q;
	logic [SXW-1:0]  sx_q, sy_q;
	logic [SIXW-1:0] six_q, siy_q;
	logic [S2XW-1:0] s2x_q, s2y_q;
	logic            ov_q;
	logic [CB-1:0]   pxm, pym;
	logic            room;

	assign pxm  = px[CB-1:0];
	assign pym  = py[CB-1:0];
	assign room = cnt_q < CW'(MAX_POINTS);

	// powers of the next index follow by binomial steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; p2_q <= '0; p3_q <= '0; p4_q <= '0;
			s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0;
			sx_q <= '0; six_q <= '0; s2x_q <= '0;
			sy_q <= '0; siy_q <= '0; s2y_q <= '0;
			ov_q <= 1'b0;
		end else if (clr) begin
			cnt_q <= '0; p2_q <= '0; p3_q <= '0; p4_q <= '0;
			s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0;
			sx_q <= '0; six_q <= '0; s2x_q <= '0;
			sy_q <= '0; siy_q <= '0; s2y_q <= '0;
			ov_q <= 1'b0;
		end else if (take) begin
			if (room) begin
				s1_q  <= s1_q + S1W'(cnt_q);
				s2_q  <= s2_q + S2W'(p2_q);
				s3_q  <= s3_q + S3W'(p3_q);
				s4_q  <= s4_q + S4W'(p4_q);
				sx_q  <= sx_q + SXW'(pxm);
				sy_q  <= sy_q + SXW'(pym);
				six_q <= six_q + SIXW'(cnt_q) * SIXW'(pxm);
				siy_q <= siy_q + SIXW'(cnt_q) * SIXW'(pym);
				s2x_q <= s2x_q + S2XW'(p2_q) * S2XW'(pxm);
				s2y_q <= s2y_q + S2XW'(p2_q) * S2XW'(pym);
				p2_q  <= p2_q + (P2W'(cnt_q) << 1) + P2W'(1);
				p3_q  <= p3_q + (P3W'(p2_q) << 1) + P3W'(p2_q)
					+ (P3W'(cnt_q) << 1) + P3W'(cnt_q) + P3W'(1);
				p4_q  <= p4_q + (P4W'(p3_q) << 2) + (P4W'(p2_q) << 2) + (P4W'(p2_q) << 1)
					+ (P4W'(cnt_q) << 2) + P4W'(1);
				cnt_q <= cnt_q + CW'(1);
			end else begin
				ov_q <= 1'b1;
			end
		end
	end

	assign sums.a  = OW'(s4_q);
	assign sums.b  = OW'(s3_q);
	assign sums.c  = OW'(s2_q);
	assign sums.d  = OW'(s1_q);
	assign sums.n  = OW'(cnt_q);
	assign sums.x2 = OW'(s2x_q);
	assign sums.x1 = OW'(six_q);
	assign sums.x0 = OW'(sx_q);
	assign sums.y2 = OW'(s2y_q);
	assign sums.y1 = OW'(siy_q);
	assign sums.y0 = OW'(sy_q);
	assign ov      = ov_q;

endmodule

// ----- rtl/qtls_mac.sv -----
module qtls_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              clr,
	input  logic                              neg,
	input  logic signed [qtls_pkg::OPD_W-1:0] x,
	input  logic signed [qtls_pkg::OPD_W-1:0] y,
	output logic [qtls_pkg::ACC_W-1:0]        acc,
	output logic                              busy
);
	localparam int OW = qtls_pkg::OPD_W;
	localparam int HW = OW / 2;
	localparam int AW = qtls_pkg::ACC_W;

	logic [OW-1:0] mx_q, my_q;
	logic          sub_q;
	logic [1:0]    ph_q;
	logic          run_q;
	logic [AW-1:0] acc_q;
	logic [HW-1:0] hx, hy;
	logic [OW-1:0] prod;
	logic [AW-1:0] term;
	logic [1:0]    wsum;

	// one 32x32 partial product per cycle, four per multiply
	assign hx   = ph_q[0] ? mx_q[OW-1:HW] : mx_q[HW-1:0];
	assign hy   = ph_q[1] ? my_q[OW-1:HW] : my_q[HW-1:0];
	assign prod = OW'(hx) * OW'(hy);
	assign wsum = 2'(ph_q[0]) + 2'(ph_q[1]);
	assign term = AW'(prod) << (wsum * HW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mx_q  <= '0;
			my_q  <= '0;
			sub_q <= 1'b0;
			ph_q  <= '0;
			run_q <= 1'b0;
			acc_q <= '0;
		end else if (start) begin
			mx_q  <= x[OW-1] ? OW'(-x) : OW'(x);
			my_q  <= y[OW-1] ? OW'(-y) : OW'(y);
			sub_q <= neg ^ x[OW-1] ^ y[OW-1];
			ph_q  <= '0;
			run_q <= 1'b1;
			if (clr) begin
				acc_q <= '0;
			end
		end else if (run_q) begin
			acc_q <= sub_q ? acc_q - term : acc_q + term;
			ph_q  <= ph_q + 2'd1;
			if (ph_q == 2'd3) begin
				run_q <= 1'b0;
			end
		end
	end

	assign acc  = acc_q;
	assign busy = run_q;

endmodule

// ----- rtl/qtls_div.sv -----
module qtls_div #(
	parameter int FRAC_BITS = qtls_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [qtls_pkg::ACC_W-1:0]         num,
	input  logic [qtls_pkg::ACC_W-1:0]         den,
	output logic signed [qtls_pkg::COEF_W-1:0] q,
	output logic                               busy
);
	localparam int AW    = qtls_pkg::ACC_W;
	localparam int CWD   = qtls_pkg::COEF_W;
	localparam int CNT_W = $clog2(AW);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} d_state_t;

	d_state_t          state_q;
	logic [AW-1:0]     m_q, r_q, quo_q, den_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CWD-1:0]    q_q;
	logic [AW-1:0]     rs, qr, twice, mag;
	logic              ge;

	// restoring division, one quotient bit per cycle
	assign mag   = num[AW-1] ? AW'(-num) : num;
	assign rs    = {r_q[AW-2:0], m_q[AW-1]};
	assign ge    = rs >= den_q;
	assign twice = {r_q[AW-2:0], 1'b0};
	assign qr    = quo_q + AW'(twice >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			m_q     <= '0;
			r_q     <= '0;
			quo_q   <= '0;
			den_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			q_q     <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						neg_q   <= num[AW-1];
						m_q     <= mag << FRAC_BITS;
						den_q   <= den;
						r_q     <= '0;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					r_q   <= ge ? rs - den_q : rs;
					quo_q <= {quo_q[AW-2:0], ge};
					m_q   <= m_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(AW - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					// round half away from zero, then saturate
					if (neg_q) begin
						if (qr >= (AW'(1) << (CWD - 1))) begin
							q_q <= {1'b1, {(CWD-1){1'b0}}};
						end else begin
							q_q <= CWD'(-qr);
						end
					end else begin
						if (qr > AW'({1'b0, {(CWD-1){1'b1}}})) begin
							q_q <= {1'b0, {(CWD-1){1'b1}}};
						end else begin
							q_q <= qr[CWD-1:0];
						end
					end
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign q    = q_q;
	assign busy = state_q != D_IDLE;

endmodule

// ----- rtl/qtls_solve.sv -----
module qtls_solve #(
	parameter int FRAC_BITS = qtls_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  qtls_pkg::sums_t sums,
	input  logic            res_ready,
	output logic            busy,
	output logic            fin,
	output qtls_pkg::res_t  res
);
	localparam int OW = qtls_pkg::OPD_W;
	localparam int AW = qtls_pkg::ACC_W;
	localparam int PW = qtls_pkg::PC_W;
	localparam int IW = qtls_pkg::CI_W;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_MWAIT, S_DWAIT, S_FINISH} state_t;

	state_t                            state_q;
	logic [PW-1:0]                     pc_q;
	logic [IW-1:0]                     ci_q;
	logic                              valid_q;
	logic signed [OW-1:0]              cof0_q, cof1_q, cof2_q, cof3_q, cof4_q, cof5_q;
	logic [AW-1:0]                     det_q;
	logic signed [qtls_pkg::COEF_W-1:0] coef_q [qtls_pkg::NCOEF];
	qtls_pkg::prog_t                   step;
	logic signed [OW-1:0]              xv, yv;
	logic                              mac_start, mac_busy, div_start, div_busy;
	logic [AW-1:0]                     acc;
	logic signed [qtls_pkg::COEF_W-1:0] div_q;

	assign step = qtls_pkg::prog_at(pc_q);

	function automatic logic signed [OW-1:0] opnd_val(input qtls_pkg::opnd_t op);
		logic signed [OW-1:0] v;
		case (op)
			qtls_pkg::OP_A:  v = sums.a;
			qtls_pkg::OP_B:  v = sums.b;
			qtls_pkg::OP_C:  v = sums.c;
			qtls_pkg::OP_D:  v = sums.d;
			qtls_pkg::OP_N:  v = sums.n;
			qtls_pkg::OP_C0: v = cof0_q;
			qtls_pkg::OP_C1: v = cof1_q;
			qtls_pkg::OP_C2: v = cof2_q;
			qtls_pkg::OP_C3: v = cof3_q;
			qtls_pkg::OP_C4: v = cof4_q;
			qtls_pkg::OP_C5: v = cof5_q;
			qtls_pkg::OP_X2: v = sums.x2;
			qtls_pkg::OP_X1: v = sums.x1;
			qtls_pkg::OP_X0: v = sums.x0;
			qtls_pkg::OP_Y2: v = sums.y2;
			qtls_pkg::OP_Y1: v = sums.y1;
			qtls_pkg::OP_Y0: v = sums.y0;
			default:         v = '0;
		endcase
		return v;
	endfunction

	always_comb xv = opnd_val(step.xs);
	always_comb yv = opnd_val(step.ys);
	assign mac_start = state_q == S_ISSUE;
	assign div_start = (state_q == S_MWAIT) && !mac_busy && (step.dst == qtls_pkg::DST_NUM);

	qtls_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.clr    (step.first),
		.neg    (step.neg),
		.x      (xv),
		.y      (yv),
		.acc    (acc),
		.busy   (mac_busy)
	);

	qtls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc),
		.den    (det_q),
		.q      (div_q),
		.busy   (div_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			ci_q    <= '0;
			valid_q <= 1'b0;
			cof0_q  <= '0; cof1_q <= '0; cof2_q <= '0;
			cof3_q  <= '0; cof4_q <= '0; cof5_q <= '0;
			det_q   <= '0;
			for (int k = 0; k < qtls_pkg::NCOEF; k++) begin
				coef_q[k] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					pc_q    <= '0;
					ci_q    <= '0;
					valid_q <= 1'b0;
					for (int k = 0; k < qtls_pkg::NCOEF; k++) begin
						coef_q[k] <= '0;
					end
					state_q <= (sums.n < OW'(3)) ? S_FINISH : S_ISSUE;
				end
				S_ISSUE: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (!mac_busy) begin
						pc_q    <= pc_q + PW'(1);
						state_q <= S_ISSUE;
						case (step.dst)
							qtls_pkg::DST_COF0: cof0_q <= acc[OW-1:0];
							qtls_pkg::DST_COF1: cof1_q <= acc[OW-1:0];
							qtls_pkg::DST_COF2: cof2_q <= acc[OW-1:0];
							qtls_pkg::DST_COF3: cof3_q <= acc[OW-1:0];
							qtls_pkg::DST_COF4: cof4_q <= acc[OW-1:0];
							qtls_pkg::DST_COF5: cof5_q <= acc[OW-1:0];
							qtls_pkg::DST_DET: begin
								det_q <= acc;
								// singular or negative determinant gives no fit
								if (acc[AW-1] || (acc == '0)) begin
									state_q <= S_FINISH;
								end
							end
							qtls_pkg::DST_NUM: begin
								pc_q    <= pc_q;
								state_q <= S_DWAIT;
							end
							default: ;
						endcase
					end
				end
				S_DWAIT: begin
					if (!div_busy) begin
						coef_q[ci_q] <= div_q;
						ci_q         <= ci_q + IW'(1);
						if (pc_q == qtls_pkg::PC_LAST) begin
							valid_q <= 1'b1;
							state_q <= S_FINISH;
						end else begin
							pc_q    <= pc_q + PW'(1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = state_q != S_IDLE;
	assign fin           = state_q == S_FINISH;
	assign res.x_quad    = coef_q[0];
	assign res.x_lin     = coef_q[1];
	assign res.x_const   = coef_q[2];
	assign res.y_quad    = coef_q[3];
	assign res.y_lin     = coef_q[4];
	assign res.y_const   = coef_q[5];
	assign res.fit_valid = valid_q;

	// multiplier and divider never run together
	a_unit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mac_busy && div_busy))
		else $error("mac and divider busy together");

	// a new track only starts a solve when the sequencer is free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == S_IDLE))
		else $error("solve started while busy");

	// a valid fit needs at least three points
	a_valid_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && valid_q) |-> (sums.n >= OW'(3)))
		else $error("fit valid with too few points");

endmodule

// ----- rtl/quadratic_track_least_squares_fit.sv -----
// Fits x(i) and y(i) = q*i^2 + l*i + c over one track of points, i counted from 0.
// A point without the last mark is taken while no solve runs. A last point starts the solve: one shared
// 32x32 multiplier builds six cofactors, the determinant and six numerators over 33 product
// terms, and a radix-2 divider then forms each of the six coefficients bit by bit; the point
// input is held off until the result request is loaded. With fewer than three points the
// result comes with zero coefficients and fit_valid low. A finished request waits in an output
// register; accumulation of the next track carries on while it waits.
module quadratic_track_least_squares_fit #(
	parameter int MAX_POINTS = qtls_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = qtls_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = qtls_pkg::FRAC_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	qtls_pt_if.sink      pt,
	qtls_fit_if.source   fit
);
	qtls_pkg::sums_t sums;
	qtls_pkg::res_t  res, res_q;
	logic            take, start, ov, busy, fin, res_load;
	logic            out_v_q, drop_q;

	assign take     = pt.valid && pt.ready;
	assign start    = take && pt.last_point;
	assign pt.ready = !busy;
	assign res_load = fin && (!out_v_q || fit.ready);

	qtls_accum #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.px     (pt.point_x),
		.py     (pt.point_y),
		.clr    (res_load),
		.sums   (sums),
		.ov     (ov)
	);

	qtls_solve #(.FRAC_BITS(FRAC_BITS)) u_solve (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sums      (sums),
		.res_ready (res_load),
		.busy      (busy),
		.fin       (fin),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			res_q   <= '0;
			drop_q  <= 1'b0;
		end else if (res_load) begin
			out_v_q <= 1'b1;
			res_q   <= res;
			drop_q  <= ov;
		end else if (fit.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign fit.valid          = out_v_q;
	assign fit.x_quad         = res_q.x_quad;
	assign fit.x_lin          = res_q.x_lin;
	assign fit.x_const        = res_q.x_const;
	assign fit.y_quad         = res_q.y_quad;
	assign fit.y_lin          = res_q.y_lin;
	assign fit.y_const        = res_q.y_const;
	assign fit.fit_valid      = res_q.fit_valid;
	assign fit.points_dropped = drop_q;

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXP = qtls_pkg::MAX_POINTS_DEF;
	localparam int FRACB = qtls_pkg::FRAC_BITS_DEF;
	localparam int PTW = qtls_pkg::PT_W;

	typedef struct packed {
		logic signed [qtls_pkg::COEF_W-1:0] x_quad;
		logic signed [qtls_pkg::COEF_W-1:0] x_lin;
		logic signed [qtls_pkg::COEF_W-1:0] x_const;
		logic signed [qtls_pkg::COEF_W-1:0] y_quad;
		logic signed [qtls_pkg::COEF_W-1:0] y_lin;
		logic signed [qtls_pkg::COEF_W-1:0] y_const;
		logic                               fit_valid;
		logic                               points_dropped;
	} fit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int src_idle = 0;
	int snk_idle = 0;
	int errors = 0;

	qtls_pt_if pt ();
	qtls_fit_if fit ();

	quadratic_track_least_squares_fit dut (
		.clk(clk), .arst_n(arst_n), .pt(pt.sink), .fit(fit.source)
	);

	always #5 clk = ~clk;

	// track accumulators
	int unsigned      n_pts;
	longint unsigned  s1, s2, s3, s4, sx0, sx1, sx2, sy0, sy1, sy2;
	logic             dropped;
	fit_t             fits_due[$];

	function automatic void clear_track();
		n_pts = 0;
		s1 = 0; s2 = 0; s3 = 0; s4 = 0;
		sx0 = 0; sx1 = 0; sx2 = 0; sy0 = 0; sy1 = 0; sy2 = 0;
		dropped = 1'b0;
	endfunction

	function automatic logic [qtls_pkg::COEF_W-1:0] to_q(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] m, q, r;
		logic neg;
		neg = num[127];
		m = neg ? -num : num;
		m = m << FRACB;
		q = m / den;
		r = m % den;
		if ((r << 1) >= den)
			q = q + 1;
		if (neg) begin
			if (q >= 128'h8000_0000)
				return 32'h8000_0000;
			return -q[31:0];
		end
		if (q > 128'h7fff_ffff)
			return 32'h7fff_ffff;
		return q[31:0];
	endfunction

	function automatic void solve_axis(longint cof[6], logic signed [127:0] det,
			longint r2, longint r1, longint r0,
			output logic [31:0] q, output logic [31:0] l, output logic [31:0] c);
		logic signed [127:0] n0, n1, n2;
		n0 = 128'(cof[0]) * r2 + 128'(cof[1]) * r1 + 128'(cof[2]) * r0;
		n1 = 128'(cof[1]) * r2 + 128'(cof[3]) * r1 + 128'(cof[4]) * r0;
		n2 = 128'(cof[2]) * r2 + 128'(cof[4]) * r1 + 128'(cof[5]) * r0;
		q = to_q(n0, det);
		l = to_q(n1, det);
		c = to_q(n2, det);
	endfunction

	function automatic void accumulate_point(logic [qtls_pkg::PT_W-1:0] x,
			logic [qtls_pkg::PT_W-1:0] y, logic last);
		longint unsigned i, i2;
		longint a, b, c, d, n;
		longint cof[6];
		logic signed [127:0] det;
		fit_t f;
		if (n_pts < MAXP) begin
			i = n_pts;
			i2 = i * i;
			s1 += i; s2 += i2; s3 += i2 * i; s4 += i2 * i2;
			sx0 += x; sx1 += i * x; sx2 += i2 * x;
			sy0 += y; sy1 += i * y; sy2 += i2 * y;
			n_pts++;
		end else begin
			dropped = 1'b1;
		end
		if (!last)
			return;
		f = '0;
		f.points_dropped = dropped;
		if (n_pts >= 3) begin
			a = s4; b = s3; c = s2; d = s1; n = n_pts;
			cof[0] = c * n - d * d;
			cof[1] = c * d - b * n;
			cof[2] = b * d - c * c;
			cof[3] = a * n - c * c;
			cof[4] = b * c - a * d;
			cof[5] = a * c - b * b;
			det = 128'(a) * cof[0] + 128'(b) * cof[1] + 128'(c) * cof[2];
			if (det > 0) begin
				solve_axis(cof, det, sx2, sx1, sx0, f.x_quad, f.x_lin, f.x_const);
				solve_axis(cof, det, sy2, sy1, sy0, f.y_quad, f.y_lin, f.y_const);
				f.fit_valid = 1'b1;
			end
		end
		fits_due = {fits_due, f};
		clear_track();
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// result sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit.ready <= 1'b0;
		end else begin
			fit.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		fit_t w;
		if (arst_n && fit.valid && fit.ready) begin
			if (fits_due.size() == 0) begin
				report_mismatch("unexpected request", 1, 0);
			end else begin
				w = fits_due.pop_front();
				if (fit.x_quad !== w.x_quad) report_mismatch("x_quad", fit.x_quad, w.x_quad);
				if (fit.x_lin !== w.x_lin) report_mismatch("x_lin", fit.x_lin, w.x_lin);
				if (fit.x_const !== w.x_const)
					report_mismatch("x_const", fit.x_const, w.x_const);
				if (fit.y_quad !== w.y_quad) report_mismatch("y_quad", fit.y_quad, w.y_quad);
				if (fit.y_lin !== w.y_lin) report_mismatch("y_lin", fit.y_lin, w.y_lin);
				if (fit.y_const !== w.y_const)
					report_mismatch("y_const", fit.y_const, w.y_const);
				if (fit.fit_valid !== w.fit_valid)
					report_mismatch("fit_valid", fit.fit_valid, w.fit_valid);
				if (fit.points_dropped !== w.points_dropped)
					report_mismatch("points_dropped", fit.points_dropped, w.points_dropped);
			end
		end
	end

	task automatic send_point(logic [qtls_pkg::PT_W-1:0] x, logic [qtls_pkg::PT_W-1:0] y,
			logic last);
		if ($urandom_range(99) < src_idle) begin
			pt.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pt.valid <= 1'b1;
		pt.point_x <= x;
		pt.point_y <= y;
		pt.last_point <= last;
		do @(posedge clk); while (!(pt.valid && pt.ready));
		accumulate_point(x, y, last);
	endtask

	task automatic send_track(int len, int shape);
		int q, l, c0, v, w;
		q = $urandom_range(0, 20) - 10;
		l = $urandom_range(0, 60) - 30;
		c0 = $urandom_range(0, 1023);
		for (int i = 0; i < len; i++) begin
			if (shape == 0) begin
				v = $urandom_range(0, 1023);
				w = $urandom_range(0, 1023);
			end else begin
				v = (q * i * i) / 8 + l * i + c0 + $urandom_range(0, 6) - 3;
				w = c0 - l * i + $urandom_range(0, 6) - 3;
				v = v < 0 ? 0 : (v > 1023 ? 1023 : v);
				w = w < 0 ? 0 : (w > 1023 ? 1023 : w);
			end
			send_point(PTW'(v), PTW'(w), i == len - 1);
		end
	endtask

	task automatic test_short_tracks();
		send_point('0, '0, 1'b1);
		send_point('1, '0, 1'b0);
		send_point('0, '1, 1'b1);
		send_point('0, '0, 1'b0);
		send_point('1, '1, 1'b0);
		send_point('0, '0, 1'b1);
		send_point('1, '1, 1'b0);
		send_point('1, '1, 1'b0);
		send_point('1, '1, 1'b0);
		send_point('1, '1, 1'b1);
		send_point(10'd0, 10'd1023, 1'b0);
		send_point(10'd1023, 10'd0, 1'b0);
		send_point(10'd0, 10'd1023, 1'b0);
		send_point(10'd1023, 10'd0, 1'b1);
	endtask

	task automatic test_capacity();
		send_track(MAXP, 0);
		send_track(MAXP + 1, 0);
		send_track(MAXP + 5, 1);
	endtask

	task automatic test_random(int items);
		int sent, len, r;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(99);
			if (r < 8) len = $urandom_range(1, 2);
			else if (r < 95) len = $urandom_range(3, 12);
			else len = $urandom_range(40, MAXP + 6);
			send_track(len, $urandom_range(1));
			sent += len;
		end
	endtask

	initial begin
		pt.valid = 1'b0;
		pt.point_x = '0;
		pt.point_y = '0;
		pt.last_point = 1'b0;
		clear_track();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle = 21; snk_idle = 64;
		test_short_tracks();
		test_capacity();
		test_random(210);
		src_idle = 64; snk_idle = 21;
		test_random(210);
		src_idle = 0; snk_idle = 0;
		test_random(210);
		pt.valid <= 1'b0;
		while (fits_due.size() != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/qtls_pkg.sv
rtl/qtls_pt_if.sv
rtl/qtls_fit_if.sv
rtl/qtls_accum.sv
rtl/qtls_mac.sv
rtl/qtls_div.sv
rtl/qtls_solve.sv
rtl/quadratic_track_least_squares_fit.sv
verif/tb_top.sv
